// ===== rtl/assert_macros.svh =====
// assertion helpers for the clustering unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock while out of reset
`define PAC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pac assertion failed");

// check a property on every clock, reset included
`define PAC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pac assertion failed");

`endif

// ===== rtl/pac_pkg.sv =====
package pac_pkg;

  localparam int MAX_LEAVES = 32;
  localparam int IDX_W      = $clog2(MAX_LEAVES);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int VAL_W      = 16;
  localparam int CNT_W      = 6;
  localparam int LBL_W      = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [4:0]              row;
    logic [4:0]              col;
    logic signed [VAL_W-1:0] value;
  } pac_in_t;

  typedef struct packed {
    logic [5:0] left_node;
    logic [5:0] right_node;
    logic [5:0] new_node;
    logic       last;
  } pac_out_t;

  typedef enum logic {
    ALU_CMP,
    ALU_AVG
  } pac_alu_op_t;

  typedef struct packed {
    logic                    gt;
    logic signed [VAL_W-1:0] avg;
  } pac_alu_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD2,
    ST_SCAN,
    ST_DRAIN,
    ST_LBL_A,
    ST_LBL_B,
    ST_MERGE
  } pac_state_t;

endpackage

// ===== rtl/pac_ram.sv =====
module pac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pac_alu.sv =====
module pac_alu (
  input  pac_pkg::pac_alu_op_t          op,
  input  logic signed [pac_pkg::VAL_W-1:0] a,
  input  logic signed [pac_pkg::VAL_W-1:0] b,
  output pac_pkg::pac_alu_res_t         res
);
  import pac_pkg::*;

  logic              sub;
  logic signed [VAL_W:0] sum;

  // one 17-bit adder: a-b for the compare, a+b for the average
  assign sub = (op == ALU_CMP);
  assign sum = {a[VAL_W-1], a} + (sub ? ~{b[VAL_W-1], b} : {b[VAL_W-1], b})
               + {{VAL_W{1'b0}}, sub};

  assign res.gt  = !sum[VAL_W] && (sum != '0);
  assign res.avg = sum[VAL_W:1];

endmodule

// ===== rtl/pairwise_average_clustering_unit.sv =====
// pairwise average clustering unit
// input: start/busy command port carrying in_item. op load writes the
// similarity entry at (row,col) and (col,row); op start clusters the first
// seq_count leaves (saturated to 32, nothing done below 2).
// config: cfg_we/cfg_wdata write seq_count (reset 32); the user must keep
// to writing only while idle, as the block itself does not enforce it.
// result: out_strobe marks out_item for exactly one cycle, one transaction
// per merge, last set on the final merge. there is no back pressure.
// timing: a load is taken and then holds busy while its mirror is written.
// a start with n leaves runs n-1 rounds; each round scans every pair, then
// a drain state and two label states, then merges every column, all bound
// by the matrix memory (one read port and one write port) and the shared
// add/compare unit; the result is strobed after the second label state.
// reset: control state clears, seq_count returns to 32; matrix contents
// are undefined until loaded. the matrix after a run keeps the averaged
// rows, which later starts see.
`include "assert_macros.svh"
module pairwise_average_clustering_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pac_pkg::pac_in_t  in_item,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_wdata,
  output logic              out_strobe,
  output pac_pkg::pac_out_t out_item
);
  import pac_pkg::*;

  pac_state_t state_r, state_nxt;

  logic [CNT_W-1:0] seq_count_r;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] i_r, j_r, a_r, b_r, mj_r, pi_r, pj_r;
  logic [2:0]       k_r;
  logic [IDX_W-1:0] round_r;
  logic             pv_r, found_r;
  logic [MAX_LEAVES-1:0] act_r;
  logic [LBL_W-1:0] lbl_r [MAX_LEAVES];
  logic [LBL_W-1:0] la_r, next_r, lbl_rd;
  logic [IDX_W-1:0] lbl_addr;
  logic signed [VAL_W-1:0] best_r, x_r, avg_r, mval;
  logic [4:0]       ld_row_r, ld_col_r;
  logic [VAL_W-1:0] ld_val_r;
  logic             scan_end, merge_end, take;

  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  pac_alu_op_t  alu_op;
  logic signed [VAL_W-1:0] alu_a, alu_b;
  pac_alu_res_t alu_res;
  pac_out_t     out_r;
  logic         out_strobe_r;

  pac_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEAVES * MAX_LEAVES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pac_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign n_eff = (seq_count_r > CNT_W'(MAX_LEAVES)) ? CNT_W'(MAX_LEAVES) : seq_count_r;
  assign busy  = (state_r != ST_IDLE);
  assign take  = start && !busy;
  assign scan_end  = ({1'b0, i_r} == n_r - CNT_W'(2)) && ({1'b0, j_r} == n_r - CNT_W'(1));
  assign merge_end = ({1'b0, mj_r} == n_r - CNT_W'(1)) && (k_r == 3'd5);
  assign lbl_addr  = (state_r == ST_LBL_B) ? b_r : a_r;
  assign lbl_rd    = lbl_r[lbl_addr];

  assign alu_op = (state_r == ST_MERGE) ? ALU_AVG : ALU_CMP;
  assign alu_a  = (state_r == ST_MERGE) ? x_r : $signed(ram_rdata);
  assign alu_b  = (state_r == ST_MERGE) ? $signed(ram_rdata) : best_r;
  assign mval   = (mj_r == a_r || mj_r == b_r) ? '0 : alu_res.avg;

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {ld_row_r, ld_col_r};
    ram_wdata = ld_val_r;
    ram_raddr = {i_r, j_r};
    unique case (state_r)
      ST_IDLE: begin
        ram_we    = take && (in_item.op == OP_LOAD);
        ram_waddr = {in_item.row, in_item.col};
        ram_wdata = in_item.value;
      end
      ST_LOAD2: begin
        ram_we    = 1'b1;
        ram_waddr = {ld_col_r, ld_row_r};
      end
      ST_MERGE: begin
        ram_raddr = (k_r == 3'd0) ? {a_r, mj_r} : {b_r, mj_r};
        case (k_r)
          3'd2: begin
            ram_we    = 1'b1;
            ram_waddr = {a_r, mj_r};
            ram_wdata = mval;
          end
          3'd3: begin
            ram_we    = 1'b1;
            ram_waddr = {mj_r, a_r};
            ram_wdata = avg_r;
          end
          3'd4: begin
            ram_we    = 1'b1;
            ram_waddr = {b_r, mj_r};
            ram_wdata = '0;
          end
          3'd5: begin
            ram_we    = 1'b1;
            ram_waddr = {mj_r, b_r};
            ram_wdata = '0;
          end
          default: ram_we = 1'b0;
        endcase
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_item.op == OP_LOAD) begin
            state_nxt = ST_LOAD2;
          end else if (n_eff >= CNT_W'(2)) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOAD2: state_nxt = ST_IDLE;
      ST_SCAN:  if (scan_end) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_LBL_A;
      ST_LBL_A: state_nxt = ST_LBL_B;
      ST_LBL_B: state_nxt = ST_MERGE;
      ST_MERGE: begin
        if (merge_end) begin
          state_nxt = ({1'b0, round_r} + CNT_W'(2) == n_r) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seq_count_r  <= CNT_W'(MAX_LEAVES);
      out_strobe_r <= 1'b0;
      pv_r         <= 1'b0;
      found_r      <= 1'b0;
      act_r        <= '0;
      next_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      pv_r         <= 1'b0;
      if (cfg_we) begin
        seq_count_r <= cfg_wdata;
      end
      // running best of the scan, one pair per cycle behind the read
      if (pv_r && (!found_r || alu_res.gt)) begin
        best_r  <= $signed(ram_rdata);
        a_r     <= pi_r;
        b_r     <= pj_r;
        found_r <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            ld_row_r <= in_item.row;
            ld_col_r <= in_item.col;
            ld_val_r <= in_item.value;
            if (in_item.op == OP_START && n_eff >= CNT_W'(2)) begin
              n_r     <= n_eff;
              next_r  <= LBL_W'(n_eff);
              round_r <= '0;
              i_r     <= '0;
              j_r     <= IDX_W'(1);
              found_r <= 1'b0;
              for (int q = 0; q < MAX_LEAVES; q++) begin
                act_r[q] <= (CNT_W'(q) < n_eff);
                if (CNT_W'(q) < n_eff) begin
                  lbl_r[q] <= LBL_W'(q + 1);
                end
              end
            end
          end
        end
        ST_SCAN: begin
          pv_r <= act_r[i_r] && act_r[j_r];
          pi_r <= i_r;
          pj_r <= j_r;
          if ({1'b0, j_r} == n_r - CNT_W'(1)) begin
            i_r <= i_r + IDX_W'(1);
            j_r <= i_r + IDX_W'(2);
          end else begin
            j_r <= j_r + IDX_W'(1);
          end
        end
        ST_LBL_A: la_r <= lbl_rd;
        ST_LBL_B: begin
          out_strobe_r     <= 1'b1;
          out_r.left_node  <= 6'(la_r - LBL_W'(1));
          out_r.right_node <= 6'(lbl_rd - LBL_W'(1));
          out_r.new_node   <= next_r[5:0];
          out_r.last       <= ({1'b0, round_r} + CNT_W'(2) == n_r);
          lbl_r[a_r]       <= next_r + LBL_W'(1);
          act_r[b_r]       <= 1'b0;
          next_r           <= next_r + LBL_W'(1);
          mj_r             <= '0;
          k_r              <= '0;
        end
        ST_MERGE: begin
          if (k_r == 3'd1) begin
            x_r <= $signed(ram_rdata);
          end
          if (k_r == 3'd2) begin
            avg_r <= mval;
          end
          if (k_r == 3'd5) begin
            k_r  <= '0;
            mj_r <= mj_r + IDX_W'(1);
          end else begin
            k_r <= k_r + 3'd1;
          end
          if (merge_end) begin
            round_r <= round_r + IDX_W'(1);
            i_r     <= '0;
            j_r     <= IDX_W'(1);
            found_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `PAC_ASSERT(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe)
  `PAC_ASSERT(a_strobe_then_merge, clk, rst_n, out_strobe |-> state_r == ST_MERGE)
  `PAC_ASSERT(a_strobe_found, clk, rst_n, out_strobe |-> found_r && !act_r[b_r])
  `PAC_ASSERT_ALWAYS(a_idle_quiet, clk, (rst_n && state_r == ST_IDLE) |=> !out_strobe)

endmodule

// ===== tb/sv/pairwise_average_clustering_unit_tb.sv =====
module pairwise_average_clustering_unit_tb;
  import pac_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  pac_in_t  in_item = '0;
  logic     cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;
  logic     out_strobe;
  pac_out_t out_item;

  pairwise_average_clustering_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_strobe(out_strobe), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // stimulus side
  pac_in_t pending_cmds[$];
  bit      written[MAX_LEAVES][MAX_LEAVES];
  int      gen_leaves = 32;
  int      idle_pct = 0;
  int      items_made = 0;

  // predictor side
  logic signed [VAL_W-1:0] sim[MAX_LEAVES][MAX_LEAVES];
  logic [LBL_W-1:0]        label[MAX_LEAVES];
  logic [LBL_W-1:0]        next_id;
  logic [5:0]              leaf_reg;
  pac_out_t                merges_due[$];

  logic in_acc = 1'b0;
  int   fails = 0;
  int   idle_cycles = 0;
  int   n_loads = 0, n_starts = 0, n_merges = 0;

  task automatic cluster_merges();
    int n, a, b, best, i, j, rnd;
    bit found;
    pac_out_t r;
    n = (leaf_reg > MAX_LEAVES) ? MAX_LEAVES : leaf_reg;
    if (n < 2) return;
    for (i = 0; i < n; i++) label[i] = LBL_W'(i + 1);
    next_id = LBL_W'(n);
    for (rnd = 0; rnd + 1 < n; rnd++) begin
      found = 0; a = 0; b = 1; best = 0;
      for (i = 0; i + 1 < n; i++) begin
        if (label[i] == 0) continue;
        for (j = i + 1; j < n; j++) begin
          if (label[j] == 0) continue;
          if (!found || int'(sim[i][j]) > best) begin
            best = sim[i][j]; a = i; b = j; found = 1;
          end
        end
      end
      r.left_node  = 6'(label[a] - 1);
      r.right_node = 6'(label[b] - 1);
      r.new_node   = next_id[5:0];
      r.last       = (rnd + 2 == n);
      merges_due.push_back(r);
      label[a] = next_id + 1;
      label[b] = 0;
      next_id  = next_id + 1;
      // floor of the pair mean, arithmetic shift rounds toward minus infinity
      for (j = 0; j < n; j++)
        if (j != b) sim[a][j] = VAL_W'((int'(sim[a][j]) + int'(sim[b][j])) >>> 1);
      sim[a][a] = 0;
      for (j = 0; j < n; j++) begin
        sim[j][a] = sim[a][j];
        sim[j][b] = 0;
        sim[b][j] = 0;
      end
    end
  endtask

  // input transaction accept, prediction, config mirror, result check, watchdog
  always @(posedge clk) begin
    in_acc <= start && !busy;
    if (!rst_n) begin
      leaf_reg <= 6'd32;
    end else begin
      if (cfg_we) leaf_reg <= cfg_wdata;
      if (start && !busy) begin
        if (in_item.op == OP_LOAD) begin
          sim[in_item.row][in_item.col] = in_item.value;
          sim[in_item.col][in_item.row] = in_item.value;
          n_loads++;
        end else begin
          n_starts++;
          cluster_merges();
        end
      end
      if (out_strobe) begin
        if (merges_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
          fails++;
        end else begin
          pac_out_t e;
          e = merges_due.pop_front();
          n_merges++;
          if (out_item.left_node !== e.left_node) begin
            $display("%0t: left_node expected %0d actual %0d", $time, e.left_node,
                     out_item.left_node);
            fails++;
          end
          if (out_item.right_node !== e.right_node) begin
            $display("%0t: right_node expected %0d actual %0d", $time, e.right_node,
                     out_item.right_node);
            fails++;
          end
          if (out_item.new_node !== e.new_node) begin
            $display("%0t: new_node expected %0d actual %0d", $time, e.new_node,
                     out_item.new_node);
            fails++;
          end
          if (out_item.last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, out_item.last);
            fails++;
          end
        end
      end
      if ((start && !busy) || out_strobe) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (in_acc) void'(pending_cmds.pop_front());
    if (start && !in_acc) begin
      // held until taken
    end else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start   <= 1'b1;
      in_item <= pending_cmds[0];
    end else begin
      start <= 1'b0;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(3))
      0: return 16'($signed($urandom_range(4)) - 2);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_load(int r, int c, logic [15:0] v);
    pac_in_t t;
    t.op = OP_LOAD; t.row = r[4:0]; t.col = c[4:0]; t.value = v;
    pending_cmds.push_back(t);
    written[r][c] = 1;
    written[c][r] = 1;
    items_made++;
  endtask

  task automatic add_start();
    pac_in_t t;
    int i, j;
    t.op = OP_START; t.row = 5'($urandom); t.col = 5'($urandom); t.value = 16'($urandom);
    pending_cmds.push_back(t);
    items_made++;
    if (gen_leaves >= 2)
      for (i = 0; i < gen_leaves; i++)
        for (j = 0; j < gen_leaves; j++) written[i][j] = 1;
  endtask

  task automatic fill_block();
    int i, j;
    for (i = 0; i < gen_leaves; i++)
      for (j = i; j < gen_leaves; j++)
        if (!written[i][j]) add_load(i, j, pick_value());
  endtask

  // all queued work taken, all results in, block settled
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || busy || merges_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_leaves(logic [5:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_leaves = (v > MAX_LEAVES) ? MAX_LEAVES : v;
  endtask

  task automatic random_phase(int pct, int target);
    int lim;
    idle_pct = pct;
    lim = items_made + target;
    while (items_made < lim) begin
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(19))
          0:       set_leaves(6'($urandom_range(1)));
          1:       set_leaves(6'($urandom_range(10, 9)));
          default: set_leaves(6'($urandom_range(8, 2)));
        endcase
      end
      fill_block();
      repeat ($urandom_range(4)) begin
        if ($urandom_range(3) != 0 && gen_leaves >= 2)
          add_load($urandom_range(gen_leaves - 1), $urandom_range(gen_leaves - 1),
                   pick_value());
        else
          add_load($urandom_range(31), $urandom_range(31), pick_value());
      end
      add_start();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: smallest tree, extreme values, full ties, too few leaves
    set_leaves(6'd2);
    add_load(0, 1, 16'h7fff);
    add_start();
    set_leaves(6'd3);
    add_load(0, 2, 16'h8000);
    add_load(1, 2, 16'h8000);
    add_start();
    set_leaves(6'd4);
    for (int i = 0; i < 4; i++)
      for (int j = i; j < 4; j++) add_load(i, j, 16'h0000);
    add_start();
    add_load(2, 3, 16'hffff);
    add_load(1, 3, 16'hffff);
    add_start();
    set_leaves(6'd0);
    add_start();
    set_leaves(6'd1);
    add_start();
    set_leaves(6'd5);
    add_load(31, 31, 16'h5555);
    fill_block();
    add_start();

    random_phase(11, 40);
    random_phase(86, 40);
    drain();
    random_phase(0, 40);

    drain();
    $display("covered %0d loads, %0d starts, %0d merges checked", n_loads, n_starts,
             n_merges);
    $display("leaf counts 0..10, ties, extreme q8.8 values, idle mixes");
    if (fails == 0 && merges_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== pairwise_average_clustering_unit.f =====
+incdir+rtl
rtl/pac_pkg.sv
rtl/pac_ram.sv
rtl/pac_alu.sv
rtl/pairwise_average_clustering_unit.sv
tb/sv/pairwise_average_clustering_unit_tb.sv
